// File: src/msgd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msgd_pkg
// Shared types and constants for the momentum SGD weight update block.
// ----------------------------------------------------------------------------
package msgd_pkg;

  // default sizes
  localparam int NUM_ELEMS_DEF = 4096;
  localparam int VAL_WIDTH_DEF = 32;

  // fixed field widths
  localparam int IDX_W     = 12;
  localparam int COEF_W    = 16;
  localparam int FRAC_BITS = 16;
  localparam int CFG_IDX_W = 2;

  // register reset values
  localparam logic [COEF_W-1:0] LEARN_RATE_RST    = 16'd655;
  localparam logic [COEF_W-1:0] DECAY_RATE_RST    = 16'd0;
  localparam logic [COEF_W-1:0] MOMENTUM_GAIN_RST = 16'd58982;

  // register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEARN_RATE    = 2'd0,
    REG_DECAY_RATE    = 2'd1,
    REG_MOMENTUM_GAIN = 2'd2
  } cfg_reg_t;

  // coefficients handed to the datapath
  typedef struct packed {
    logic [COEF_W-1:0] learn;     // step size, Q0.16
    logic [COEF_W-1:0] wl;        // decay * rate, rounded to Q0.16
    logic [COEF_W-1:0] momentum;  // momentum gain, Q0.16
  } coef_t;

  // pipeline control states
  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_t;

endpackage

// File: src/msgd_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msgd channel interfaces
// Valid/ready channels for input beats, result beats and register writes.
// ----------------------------------------------------------------------------

// input beat: element index, weight and gradient
interface msgd_item_if #(
  parameter int VAL_WIDTH = msgd_pkg::VAL_WIDTH_DEF
);
  logic                            valid;
  logic                            ready;
  logic [msgd_pkg::IDX_W-1:0]      elem_index;
  logic signed [VAL_WIDTH-1:0]     weight_in;
  logic signed [VAL_WIDTH-1:0]     grad_in;

  modport source (output valid, elem_index, weight_in, grad_in, input ready);
  modport sink   (input valid, elem_index, weight_in, grad_in, output ready);
endinterface

// result beat: updated weight and saturation flag
interface msgd_result_if #(
  parameter int VAL_WIDTH = msgd_pkg::VAL_WIDTH_DEF
);
  logic                            valid;
  logic                            ready;
  logic signed [VAL_WIDTH-1:0]     weight_out;
  logic                            sat_flag;

  modport source (output valid, weight_out, sat_flag, input ready);
  modport sink   (input valid, weight_out, sat_flag, output ready);
endinterface

// register write beat
interface msgd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [msgd_pkg::CFG_IDX_W-1:0]    index;
  logic [msgd_pkg::COEF_W-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/msgd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msgd_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module msgd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wa,
  input  logic [WIDTH-1:0] wd,
  input  logic             re,
  input  logic [AW-1:0]    ra,
  output logic [WIDTH-1:0] rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // registered read, holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rd <= mem[ra];
    end
  end

endmodule

// File: src/msgd_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msgd_cfg
// Coefficient registers and the precomputed decay * rate product.
// ----------------------------------------------------------------------------
module msgd_cfg (
  input  logic            clk,
  input  logic            rst,
  msgd_cfg_if.sink        cfg,
  output msgd_pkg::coef_t coef
);
  import msgd_pkg::*;

  logic [COEF_W-1:0]   learn_rate;
  logic [COEF_W-1:0]   decay_rate;
  logic [COEF_W-1:0]   momentum_gain;
  logic [COEF_W-1:0]   wl;
  logic [2*COEF_W-1:0] wl_prod;

  // writes are always taken
  assign cfg.ready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      learn_rate    <= LEARN_RATE_RST;
      decay_rate    <= DECAY_RATE_RST;
      momentum_gain <= MOMENTUM_GAIN_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_LEARN_RATE:    learn_rate    <= cfg.data;
        REG_DECAY_RATE:    decay_rate    <= cfg.data;
        REG_MOMENTUM_GAIN: momentum_gain <= cfg.data;
        default: ;
      endcase
    end
  end

  // decay * rate rounded to Q0.16; zero decay gives zero
  assign wl_prod = (2*COEF_W)'(decay_rate) * (2*COEF_W)'(learn_rate)
                 + (2*COEF_W)'(1 << (FRAC_BITS - 1));

  always_ff @(posedge clk) begin
    wl <= wl_prod[FRAC_BITS +: COEF_W];
  end

  assign coef.learn    = learn_rate;
  assign coef.wl       = wl;
  assign coef.momentum = momentum_gain;

endmodule

// File: src/msgd_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msgd_pipe
// Five-stage read-modify-write pipeline over the velocity RAM, with the
// post-reset clearing sweep and the same-index interlock.
// ----------------------------------------------------------------------------
module msgd_pipe #(
  parameter int NUM_ELEMS = msgd_pkg::NUM_ELEMS_DEF,
  parameter int VAL_WIDTH = msgd_pkg::VAL_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  msgd_pkg::coef_t coef,
  msgd_item_if.sink       item,
  msgd_result_if.source   result
);
  import msgd_pkg::*;

  localparam int VW     = VAL_WIDTH;
  localparam int RW     = VW + 1;             // rounded product
  localparam int EW     = VW + 2;             // sum before clamp
  localparam int PW     = VW + COEF_W + 1;    // coefficient * value
  localparam int ADDR_W = (NUM_ELEMS > 1) ? $clog2(NUM_ELEMS) : 1;

  localparam logic signed [PW-1:0] HALF_P = PW'(1) << (FRAC_BITS - 1);
  localparam logic signed [EW-1:0] VMAX_E = {3'b000, {(VW-1){1'b1}}};
  localparam logic signed [EW-1:0] VMIN_E = {3'b111, {(VW-1){1'b0}}};

  // clamp to the value range, flag in the top bit
  function automatic logic [VW:0] sat_fn(input logic signed [EW-1:0] x);
    logic [VW:0] r;
    if (x > VMAX_E) begin
      r = {1'b1, VMAX_E[VW-1:0]};
    end else if (x < VMIN_E) begin
      r = {1'b1, VMIN_E[VW-1:0]};
    end else begin
      r = {1'b0, x[VW-1:0]};
    end
    return r;
  endfunction

  // control
  state_t state, state_next;
  logic [ADDR_W-1:0] clear_cnt;
  logic clearing;
  logic free1, free2, free3, free4, free5, free_out;
  logic accept, hazard;
  logic [31:0] acc_wide;
  logic [ADDR_W-1:0] acc_addr;
  logic acc_inr;

  // stage registers
  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid, out_valid;
  logic [ADDR_W-1:0] s1_addr, s2_addr, s3_addr, s4_addr;
  logic s1_inr, s2_inr, s3_inr, s4_inr;
  logic signed [VW-1:0] s1_w, s2_w, s3_w, s4_w, s5_w;
  logic signed [VW-1:0] s1_g;
  logic signed [RW-1:0] s2_d, s2_gt, s3_gt, s4_gt, s4_m;
  logic signed [VW-1:0] s2_v, s3_v1, s5_v;
  logic s3_flag, s4_flag, s5_flag;
  logic signed [VW-1:0] out_weight;
  logic out_flag;

  // datapath nets
  logic signed [PW-1:0] prod_d, prod_g, prod_m;
  logic [VW:0] sat_v1, sat_vn, sat_w;

  // memory port
  logic ram_we;
  logic [ADDR_W-1:0] ram_wa;
  logic [VW-1:0] ram_wd, ram_rd;

  // clearing sweep state machine
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clear_cnt <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clear_cnt <= clear_cnt + ADDR_W'(1);
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clear_cnt == ADDR_W'(NUM_ELEMS - 1)) state_next = ST_RUN;
      ST_RUN:   state_next = ST_RUN;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    unique case (state)
      ST_CLEAR: clearing = 1'b1;
      ST_RUN:   clearing = 1'b0;
      default:  clearing = 1'b1;
    endcase
  end

  // flow control: a stage loads when it is empty or its item moves on
  assign free_out = !out_valid || result.ready;
  assign free5    = !s5_valid || free_out;
  assign free4    = !s4_valid || free5;
  assign free3    = !s3_valid || free4;
  assign free2    = !s2_valid || free3;
  assign free1    = !s1_valid || free2;

  // incoming index decode
  assign acc_wide = 32'(item.elem_index);
  assign acc_addr = acc_wide[ADDR_W-1:0];
  assign acc_inr  = acc_wide < 32'(NUM_ELEMS);

  // hold off a beat whose entry has a write still in flight
  assign hazard = acc_inr && (
      (s1_valid && s1_inr && s1_addr == acc_addr) ||
      (s2_valid && s2_inr && s2_addr == acc_addr) ||
      (s3_valid && s3_inr && s3_addr == acc_addr) ||
      (s4_valid && s4_inr && s4_addr == acc_addr));

  assign item.ready = !clearing && free1 && !hazard;
  assign accept     = item.valid && item.ready;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      s5_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (free1)    s1_valid  <= accept;
      if (free2)    s2_valid  <= s1_valid;
      if (free3)    s3_valid  <= s2_valid;
      if (free4)    s4_valid  <= s3_valid;
      if (free5)    s5_valid  <= s4_valid;
      if (free_out) out_valid <= s5_valid;
    end
  end

  // stage 1: capture the beat, velocity read issued
  always_ff @(posedge clk) begin
    if (free1) begin
      s1_addr <= acc_addr;
      s1_inr  <= acc_inr;
      s1_w    <= item.weight_in;
      s1_g    <= item.grad_in;
    end
  end

  // stage 2: decay and gradient products, rounded
  assign prod_d = $signed({1'b0, coef.wl}) * s1_w;
  assign prod_g = $signed({1'b0, coef.learn}) * s1_g;

  always_ff @(posedge clk) begin
    if (free2) begin
      s2_addr <= s1_addr;
      s2_inr  <= s1_inr;
      s2_w    <= s1_w;
      s2_d    <= RW'((prod_d + HALF_P) >>> FRAC_BITS);
      s2_gt   <= RW'((prod_g + HALF_P) >>> FRAC_BITS);
      s2_v    <= s1_inr ? ram_rd : '0;
    end
  end

  // stage 3: velocity minus decay term
  assign sat_v1 = sat_fn(EW'(s2_v) - EW'(s2_d));

  always_ff @(posedge clk) begin
    if (free3) begin
      s3_addr <= s2_addr;
      s3_inr  <= s2_inr;
      s3_w    <= s2_w;
      s3_gt   <= s2_gt;
      s3_v1   <= sat_v1[VW-1:0];
      s3_flag <= sat_v1[VW];
    end
  end

  // stage 4: momentum product, rounded
  assign prod_m = $signed({1'b0, coef.momentum}) * s3_v1;

  always_ff @(posedge clk) begin
    if (free4) begin
      s4_addr <= s3_addr;
      s4_inr  <= s3_inr;
      s4_w    <= s3_w;
      s4_gt   <= s3_gt;
      s4_m    <= RW'((prod_m + HALF_P) >>> FRAC_BITS);
      s4_flag <= s3_flag;
    end
  end

  // stage 5: new velocity, written back as the beat moves on
  assign sat_vn = sat_fn(EW'(s4_m) - EW'(s4_gt));

  always_ff @(posedge clk) begin
    if (free5) begin
      s5_w    <= s4_w;
      s5_v    <= sat_vn[VW-1:0];
      s5_flag <= s4_flag | sat_vn[VW];
    end
  end

  // output register: weight plus velocity
  assign sat_w = sat_fn(EW'(s5_w) + EW'(s5_v));

  always_ff @(posedge clk) begin
    if (free_out) begin
      out_weight <= sat_w[VW-1:0];
      out_flag   <= s5_flag | sat_w[VW];
    end
  end

  assign result.valid      = out_valid;
  assign result.weight_out = out_weight;
  assign result.sat_flag   = out_flag;

  // velocity RAM: sweep writes zeros, then stage 4 writes back
  assign ram_we = clearing || (s4_valid && free5 && s4_inr);
  assign ram_wa = clearing ? clear_cnt : s4_addr;
  assign ram_wd = clearing ? '0 : sat_vn[VW-1:0];

  msgd_ram #(
    .WIDTH (VW),
    .DEPTH (NUM_ELEMS),
    .AW    (ADDR_W)
  ) u_vel_ram (
    .clk (clk),
    .we  (ram_we),
    .wa  (ram_wa),
    .wd  (ram_wd),
    .re  (accept),
    .ra  (acc_addr),
    .rd  (ram_rd)
  );

  // a read never lands on the entry being written in the same cycle
  a_no_rw_collide: assert property (@(posedge clk) disable iff (rst)
    accept && acc_inr && ram_we |-> ram_wa != acc_addr)
    else $error("velocity read collides with write-back");

  // the pipeline is empty for the whole clearing sweep
  a_empty_while_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !(s1_valid || s2_valid || s3_valid || s4_valid || s5_valid || out_valid))
    else $error("beat in flight during clearing sweep");

  // a stalled write-back stage keeps its entry
  a_s4_hold: assert property (@(posedge clk) disable iff (rst)
    s4_valid && !free5 |=> s4_valid && $stable(s4_addr) && $stable(s4_m))
    else $error("stalled write-back stage lost its beat");

  // write-back stays inside the store
  a_wr_in_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> 32'(ram_wa) < 32'(NUM_ELEMS))
    else $error("velocity write outside the store");

endmodule

// File: src/momentum_sgd_weight_update_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// momentum_sgd_weight_update_top
// Path: an accepted beat passes the msgd_pipe stages and output register.
// Throughput: one beat per cycle unless results stall; a beat whose index
//   matches one of four earlier beats before write-back waits for that write.
// Reset: registers take their reset values, then a sweep zeroes every entry
//   of the velocity RAM while the input is held off.
// ----------------------------------------------------------------------------
module momentum_sgd_weight_update_top #(
  parameter int NUM_ELEMS = msgd_pkg::NUM_ELEMS_DEF,
  parameter int VAL_WIDTH = msgd_pkg::VAL_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  msgd_cfg_if.sink      cfg,
  msgd_item_if.sink     item,
  msgd_result_if.source result
);
  import msgd_pkg::*;

  coef_t coef;

  // coefficient registers
  msgd_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .coef (coef)
  );

  // update pipeline around the velocity RAM
  msgd_pipe #(
    .NUM_ELEMS (NUM_ELEMS),
    .VAL_WIDTH (VAL_WIDTH)
  ) u_pipe (
    .clk    (clk),
    .rst    (rst),
    .coef   (coef),
    .item   (item),
    .result (result)
  );

endmodule

// File: bench/tb_momentum_sgd_weight_update_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_momentum_sgd_weight_update_top
// Self-checking bench for the momentum SGD weight update block. Update beats
// and coefficient writes come from queues filled by the stimulus sequence; a
// bit-accurate Q16.16 predictor with its own velocity copy computes each
// updated weight and saturation flag, and the result monitor checks them in
// order. The update input idles and the result channel stalls at random.
// ----------------------------------------------------------------------------
module tb_momentum_sgd_weight_update_top;
  import msgd_pkg::*;

  localparam int VW           = VAL_WIDTH_DEF;
  localparam int NE           = NUM_ELEMS_DEF;
  localparam int DRAIN_CYCLES = 12;
  localparam int MAX_PRINTS   = 20;

  localparam longint VMAX = (longint'(1) <<< (VW - 1)) - 1;
  localparam longint VMIN = -VMAX - 1;
  localparam longint HALF_LSB = longint'(1) <<< (FRAC_BITS - 1);

  localparam logic signed [VW-1:0] W_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] W_MIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic signed [VW-1:0] ONE_Q = 1 <<< FRAC_BITS;

  // register index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  typedef struct packed {
    logic [IDX_W-1:0]     idx;
    logic signed [VW-1:0] w;
    logic signed [VW-1:0] g;
  } upd_beat_t;

  typedef struct packed {
    logic signed [VW-1:0] w;
    logic                 sat;
  } upd_result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] idx;
    logic [COEF_W-1:0]    val;
  } reg_write_t;

  logic clk;
  logic rst;

  msgd_cfg_if                    cfg_ch ();
  msgd_item_if   #(.VAL_WIDTH(VW)) item_ch ();
  msgd_result_if #(.VAL_WIDTH(VW)) res_ch ();

  momentum_sgd_weight_update_top #(
    .NUM_ELEMS(NE),
    .VAL_WIDTH(VW)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg_ch),
    .item  (item_ch),
    .result(res_ch)
  );

  // stimulus queues and predicted weights
  upd_beat_t   update_beats_q[$];
  reg_write_t  reg_writes_q[$];
  upd_result_t predicted_weights[$];

  // predictor copy of coefficients and velocities
  logic [COEF_W-1:0] rate_q  = LEARN_RATE_RST;
  logic [COEF_W-1:0] decay_q = DECAY_RATE_RST;
  logic [COEF_W-1:0] gain_q  = MOMENTUM_GAIN_RST;
  longint            velocity_copy[NE];

  int items_queued, items_taken, writes_queued, writes_taken;
  int results_seen, sat_seen, settings_used, err_cnt;
  int src_gap, sink_stall;
  bit src_calm, sink_calm;
  upd_beat_t  nxt_beat;
  reg_write_t nxt_write;
  upd_result_t want;

  always #2 clk = ~clk;

  task automatic report_mismatch(input string what);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS) $display("mismatch %0d: %s", err_cnt, what);
  endtask

  // round half up to Q16.16
  function automatic longint round_q16(input longint x);
    return (x + HALF_LSB) >>> FRAC_BITS;
  endfunction

  function automatic longint clamp_val(input longint x, inout bit hit);
    if (x > VMAX) begin
      hit = 1'b1;
      return VMAX;
    end
    if (x < VMIN) begin
      hit = 1'b1;
      return VMIN;
    end
    return x;
  endfunction

  // one momentum step: decay, velocity update, weight update
  function automatic upd_result_t predict_update(input upd_beat_t b);
    longint      vel, w, g, wl, wn;
    bit          hit;
    upd_result_t r;
    hit = 1'b0;
    w   = $signed(b.w);
    g   = $signed(b.g);
    vel = (b.idx < NE) ? velocity_copy[b.idx] : 0;
    if (decay_q != '0) begin
      wl  = (longint'(decay_q) * longint'(rate_q) + HALF_LSB) >>> FRAC_BITS;
      vel = clamp_val(vel - round_q16(wl * w), hit);
    end
    vel = clamp_val(round_q16(longint'(gain_q) * vel) - round_q16(longint'(rate_q) * g), hit);
    if (b.idx < NE) velocity_copy[b.idx] = vel;
    wn    = clamp_val(w + vel, hit);
    r.w   = wn[VW-1:0];
    r.sat = hit;
    return r;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [VW-1:0] draw_val();
    logic signed [VW-1:0] s;
    case ($urandom_range(0, 9))
      0:       s = W_MAX;
      1:       s = W_MIN;
      2, 3:    s = $signed(VW'($urandom_range(0, 1 << 21))) - (1 << 20);
      4:       s = '0;
      default: s = $urandom;
    endcase
    return s;
  endfunction

  function automatic logic [COEF_W-1:0] draw_coef();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return COEF_W'($urandom_range(0, 2000));
      default: return COEF_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // update beat driver
  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
      src_gap = 0;
    end else if (!item_ch.valid || item_ch.ready) begin
      if (src_gap > 0) begin
        src_gap--;
        item_ch.valid <= 1'b0;
      end else if (update_beats_q.size() != 0) begin
        nxt_beat = update_beats_q.pop_front();
        item_ch.valid      <= 1'b1;
        item_ch.elem_index <= nxt_beat.idx;
        item_ch.weight_in  <= nxt_beat.w;
        item_ch.grad_in    <= nxt_beat.g;
        if ($urandom_range(0, 49) == 0) src_calm = !src_calm;
        src_gap = src_calm ? 0 : draw_gap();
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  // register write driver
  always @(posedge clk) begin
    if (rst) begin
      cfg_ch.valid <= 1'b0;
    end else if (!cfg_ch.valid || cfg_ch.ready) begin
      if (reg_writes_q.size() != 0) begin
        nxt_write = reg_writes_q.pop_front();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= nxt_write.idx;
        cfg_ch.data  <= nxt_write.val;
      end else begin
        cfg_ch.valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      sink_stall = 0;
    end else if (sink_stall > 0) begin
      sink_stall--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
      if ($urandom_range(0, 199) == 0) sink_calm = !sink_calm;
      if (!sink_calm && $urandom_range(0, 7) == 0) sink_stall = draw_gap() + 1;
    end
  end

  // track coefficient writes
  always @(posedge clk) begin
    if (!rst && cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        REG_LEARN_RATE:    rate_q  = cfg_ch.data;
        REG_DECAY_RATE:    decay_q = cfg_ch.data;
        REG_MOMENTUM_GAIN: gain_q  = cfg_ch.data;
        default: ;
      endcase
      writes_taken++;
    end
  end

  // predict every accepted update beat
  always @(posedge clk) begin
    if (!rst && item_ch.valid && item_ch.ready) begin
      predicted_weights.insert(predicted_weights.size(),
                               predict_update({item_ch.elem_index, item_ch.weight_in,
                                               item_ch.grad_in}));
      items_taken++;
    end
  end

  // check result beats in order
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      results_seen++;
      if (predicted_weights.size() == 0) begin
        report_mismatch("result beat with no update outstanding");
      end else begin
        want = predicted_weights.pop_front();
        if (want.sat) sat_seen++;
        if (res_ch.weight_out !== want.w)
          report_mismatch($sformatf("beat %0d weight_out %h, predicted %h",
                                    results_seen, res_ch.weight_out, want.w));
        if (res_ch.sat_flag !== want.sat)
          report_mismatch($sformatf("beat %0d sat_flag %b, predicted %b",
                                    results_seen, res_ch.sat_flag, want.sat));
      end
    end
  end

  task automatic send_update(input logic [IDX_W-1:0] idx, input logic signed [VW-1:0] w,
                             input logic signed [VW-1:0] g);
    update_beats_q.insert(update_beats_q.size(), '{idx: idx, w: w, g: g});
    items_queued++;
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    reg_writes_q.insert(reg_writes_q.size(), '{idx: idx, val: val});
    writes_queued++;
  endtask

  task automatic set_coefs(input logic [COEF_W-1:0] rate, input logic [COEF_W-1:0] decay,
                           input logic [COEF_W-1:0] gain);
    put_reg(REG_LEARN_RATE, rate);
    put_reg(REG_DECAY_RATE, decay);
    put_reg(REG_MOMENTUM_GAIN, gain);
    while (writes_taken != writes_queued) @(posedge clk);
    settings_used++;
  endtask

  // wait until every update has come back, then let the pipe settle
  task automatic drain();
    while (items_taken != items_queued || predicted_weights.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // random updates, half of them on a few hot elements so indexes repeat
  task automatic random_updates(input int n);
    logic [IDX_W-1:0] idx;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: idx = IDX_W'($urandom_range(0, 7));
        5:             idx = $urandom_range(0, 1) ? '1 : '0;
        default:       idx = IDX_W'($urandom_range(0, NE - 1));
      endcase
      send_update(idx, draw_val(), draw_val());
    end
  endtask

  // stimulus sequence
  initial begin
    clk                = 1'b0;
    rst                = 1'b1;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = '0;
    cfg_ch.data        = '0;
    item_ch.valid      = 1'b0;
    item_ch.elem_index = '0;
    item_ch.weight_in  = '0;
    item_ch.grad_in    = '0;
    res_ch.ready       = 1'b0;
    settings_used      = 1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset coefficients: zeros, extremes, rounding, repeated index
    send_update('0, '0, '0);
    send_update('1, W_MAX, W_MIN);
    send_update('1, W_MIN, W_MAX);
    send_update(12'd1, ONE_Q, ONE_Q >>> 1);
    send_update(12'd2, '0, -1);
    send_update(12'd2, '0, 1);
    for (int i = 0; i < 4; i++) send_update(12'd7, '0, W_MAX);
    drain();

    // every register at its maximum, plus a write to an unmapped index
    put_reg(REG_UNMAPPED, '1);
    set_coefs('1, '1, '1);
    send_update(12'd5, W_MIN, W_MIN);
    send_update(12'd5, W_MAX, W_MAX);
    send_update(12'd5, W_MIN, W_MAX);
    send_update('0, W_MAX, W_MIN);
    send_update('1, ONE_Q, -ONE_Q);
    send_update('1, -ONE_Q, ONE_Q);
    drain();

    // all coefficients zero: velocity and step vanish
    set_coefs('0, '0, '0);
    send_update(12'd5, W_MAX, W_MIN);
    send_update(12'd9, W_MIN, W_MAX);
    drain();

    // random traffic, first at reset coefficients then at random settings
    set_coefs(LEARN_RATE_RST, DECAY_RATE_RST, MOMENTUM_GAIN_RST);
    random_updates(100);
    drain();
    for (int p = 0; p < 5; p++) begin
      set_coefs(draw_coef(), draw_coef(), draw_coef());
      random_updates(60);
      drain();
    end

    $display("ran %0d update beats over %0d coefficient settings", items_taken, settings_used);
    $display("%0d results checked, %0d of them saturated", results_seen, sat_seen);
    if (err_cnt == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("timeout with %0d of %0d updates returned", results_seen, items_queued);
    $display("status: fail");
    $finish;
  end

endmodule

// File: files.f
src/msgd_pkg.sv
src/msgd_ifs.sv
src/msgd_ram.sv
src/msgd_cfg.sv
src/msgd_pipe.sv
src/momentum_sgd_weight_update_top.sv
bench/tb_momentum_sgd_weight_update_top.sv
